[rtl/sktab_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sktab_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int PAGE_W = 31;
  localparam int SLOT_W = 16;
  localparam int STAT_W = 2;
  localparam int POS_W  = 7;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_ROUTE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRD  = 9'b000000010,
    S_SCMP = 9'b000000100,
    S_FRD  = 9'b000001000,
    S_FCHK = 9'b000010000,
    S_MRD  = 9'b000100000,
    S_MWR  = 9'b001000000,
    S_PUT  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

[rtl/sorted_key_node_table_core.sv]
// Sequence: after an accepted start, all four operations run the binary search steps (at most
//   7 at 64 entries), a final read and a check; insert then moves each later entry up and
//   writes the new one, remove moves each later entry down, and the result strobe follows.
// A new word is taken only in idle; busy stays high until the result strobe has gone.
// Each search step and each moved entry is a registered read, then a compare or write.
// Reset clears the sequencer and the entry count; the receiver cannot stall out_valid.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_node_table_core #(
  parameter int CAPACITY = sktab_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sktab_pkg::KEY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [sktab_pkg::OP_W-1:0]        in_op,
  input  wire logic signed [sktab_pkg::KEY_W-1:0]  in_key,
  input  wire logic [sktab_pkg::PAGE_W-1:0]      in_rid_page,
  input  wire logic signed [sktab_pkg::SLOT_W-1:0] in_rid_slot,
  output logic                                   out_valid,
  output logic [sktab_pkg::STAT_W-1:0]           out_status,
  output logic [sktab_pkg::PAGE_W-1:0]           out_page,
  output logic signed [sktab_pkg::SLOT_W-1:0]    out_slot,
  output logic [sktab_pkg::POS_W-1:0]            out_position,
  output logic [sktab_pkg::POS_W-1:0]            out_entry_count
);
  import sktab_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = KEY_BITS + PAGE_W + SLOT_W;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt, total_r, total_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt, opage_r, opage_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt, oslot_r, oslot_nxt;
  logic [STAT_W-1:0]   status_r, status_nxt;

  logic [ENT_W-1:0] entry_mem_r [CAPACITY];
  logic [ENT_W-1:0] rd_data_r;
  logic [ENT_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en;

  logic [KEY_BITS-1:0] key_ord, rd_key;
  logic [PAGE_W-1:0]   rd_page;
  logic [SLOT_W-1:0]   rd_slot;
  logic [CNT_W:0]      mid_sum;
  logic [CNT_W-1:0]    mid, mid_inc, lo_inc, lo_dec, idx_inc, idx_dec;
  logic                key_lt, key_eq, go_left, hit;

  assign key_ord = KEY_BITS'($unsigned(in_key)) ^ {1'b1, {(KEY_BITS-1){1'b0}}};

  assign rd_key  = rd_data_r[ENT_W-1 -: KEY_BITS];
  assign rd_page = rd_data_r[SLOT_W +: PAGE_W];
  assign rd_slot = rd_data_r[SLOT_W-1:0];

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];
  assign mid_inc = mid + CNT_W'(1);
  assign lo_inc  = lo_r + CNT_W'(1);
  assign lo_dec  = lo_r - CNT_W'(1);
  assign idx_inc = idx_r + CNT_W'(1);
  assign idx_dec = idx_r - CNT_W'(1);

  assign key_lt  = rd_key < key_r;
  assign key_eq  = rd_key == key_r;
  assign go_left = (op_r == OP_ROUTE) ? (!key_lt && !key_eq) : !key_lt;
  assign hit     = (lo_r < total_r) && key_eq;

  always_comb begin
    state_nxt  = state_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    idx_nxt    = idx_r;
    total_nxt  = total_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    page_nxt   = page_r;
    slot_nxt   = slot_r;
    status_nxt = status_r;
    opage_nxt  = opage_r;
    oslot_nxt  = oslot_r;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = rd_data_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_op;
          key_nxt   = key_ord;
          page_nxt  = in_rid_page;
          slot_nxt  = in_rid_slot;
          lo_nxt    = (in_op == OP_ROUTE) ? CNT_W'(1) : '0;
          hi_nxt    = total_r;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        rd_addr   = mid[IDX_W-1:0];
        state_nxt = (lo_r < hi_r) ? S_SCMP : S_FRD;
      end
      S_SCMP: begin
        if (go_left) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid_inc;
        end
        state_nxt = S_SRD;
      end
      S_FRD: begin
        rd_addr   = (op_r == OP_ROUTE) ? lo_dec[IDX_W-1:0] : lo_r[IDX_W-1:0];
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        opage_nxt  = '0;
        oslot_nxt  = '0;
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
        case (op_r)
          OP_LOOKUP: begin
            if (hit) begin
              opage_nxt = rd_page;
              oslot_nxt = rd_slot;
            end else begin
              status_nxt = ST_MISS;
            end
          end
          OP_ROUTE: begin
            if (total_r == '0) begin
              status_nxt = ST_MISS;
            end else begin
              opage_nxt = rd_page;
              oslot_nxt = rd_slot;
            end
          end
          OP_INSERT: begin
            if (hit) begin
              status_nxt = ST_DUP;
            end else if (total_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else if (total_r > lo_r) begin
              idx_nxt   = total_r - CNT_W'(1);
              state_nxt = S_MRD;
            end else begin
              state_nxt = S_PUT;
            end
          end
          OP_REMOVE: begin
            if (!hit) begin
              status_nxt = ST_MISS;
            end else if (lo_inc < total_r) begin
              idx_nxt   = lo_inc;
              state_nxt = S_MRD;
            end else begin
              total_nxt = total_r - CNT_W'(1);
            end
          end
          default: begin
            status_nxt = ST_MISS;
          end
        endcase
      end
      S_MRD: begin
        rd_addr   = idx_r[IDX_W-1:0];
        state_nxt = S_MWR;
      end
      S_MWR: begin
        wr_en = 1'b1;
        if (op_r == OP_INSERT) begin
          wr_addr = idx_inc[IDX_W-1:0];
          if (idx_r == lo_r) begin
            state_nxt = S_PUT;
          end else begin
            idx_nxt   = idx_dec;
            state_nxt = S_MRD;
          end
        end else begin
          wr_addr = idx_dec[IDX_W-1:0];
          if (idx_inc == total_r) begin
            total_nxt = total_r - CNT_W'(1);
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_MRD;
          end
        end
      end
      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = lo_r[IDX_W-1:0];
        wr_data   = {key_r, page_r, slot_r};
        total_nxt = total_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= entry_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    idx_r    <= idx_nxt;
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    page_r   <= page_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    opage_r  <= opage_nxt;
    oslot_r  <= oslot_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_DONE);
  assign out_status      = status_r;
  assign out_page        = opage_r;
  assign out_slot        = oslot_r;
  assign out_position    = POS_W'(lo_r);
  assign out_entry_count = POS_W'(total_r);

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_idle_after_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy held after result strobe");

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted word did not start the sequencer");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (total_r == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (total_r == $past(total_r) || total_r == $past(total_r) - CNT_W'(1)
                   || total_r == $past(total_r) + CNT_W'(1)))
    else $error("entry count moved by more than one");

endmodule

`default_nettype wire
